FILE: hdl/nai64_pkg.sv
// ----------------------------------------------------------------------------
// nai64_pkg
// Shared constants, types and helpers for the null-aware int64 aggregate.
// ----------------------------------------------------------------------------
package nai64_pkg;

  // Lane count and the shape of the merge tree that follows the lanes.
  localparam int LANES    = 8;
  localparam int LEVELS   = $clog2(LANES);
  localparam int LANE_PAD = 1 << LEVELS;
  localparam int NODES    = 2 * LANE_PAD - 1;

  // Field widths.
  localparam int DATA_W  = 64;
  localparam int COUNT_W = 32;
  localparam int LANES_W = 4;
  localparam int CNT_W   = $clog2(LANES + 1);

  // The most negative 64-bit value marks a null element.
  localparam logic [DATA_W-1:0] NULL_MARK = {1'b1, {(DATA_W-1){1'b0}}};

  // What a lane or a subtree found: non-null count, sum, minimum, maximum.
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
  } partial_t;

  // Control that travels with one request down the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctl_t;

  localparam partial_t EMPTY_PARTIAL = '{cnt: '0, sum: '0, lo: NULL_MARK, hi: NULL_MARK};

  // Combine two partial results; an empty side leaves the other as it is.
  function automatic partial_t merge_pair(partial_t a, partial_t b);
    partial_t r;
    r.cnt = a.cnt + b.cnt;
    r.sum = a.sum + b.sum;
    if (a.cnt == '0) begin
      r.lo = b.lo;
      r.hi = b.hi;
    end else if (b.cnt == '0) begin
      r.lo = a.lo;
      r.hi = a.hi;
    end else begin
      r.lo = ($signed(b.lo) < $signed(a.lo)) ? b.lo : a.lo;
      r.hi = ($signed(b.hi) > $signed(a.hi)) ? b.hi : a.hi;
    end
    return r;
  endfunction

  // Pipeline stage of heap node k: the root is the last tree stage.
  function automatic int node_stage(int k);
    return LEVELS - ($clog2(k + 2) - 1);
  endfunction

endpackage

FILE: hdl/null_aware_int64_aggregate_unit.sv
// ----------------------------------------------------------------------------
// null_aware_int64_aggregate_unit
// Count, sum, minimum and maximum over a signed 64-bit column with nulls.
// ----------------------------------------------------------------------------
// Each input request carries up to eight column values (value_0..value_7),
// of which the first lanes_used are real; values above eight count as eight.
// The most negative 64-bit value is a null and is skipped. A request with
// last set closes the column: one result request follows with the saturating
// non-null count, the wrapping sum, and the minimum and maximum; with no
// non-null value the three value fields hold the null mark.
// Throughput is one input request per cycle while in_stall is low. From the
// accepted last request to out_valid the request passes one lane register,
// three merge tree levels for eight lanes (log2 of the lane count), and the
// accumulator with its result register.
// Reset (rst_n low, synchronous) empties the pipeline and clears the running
// aggregates. While out_stall holds a result, requests keep flowing until a
// further last request reaches the accumulator; the stages behind it then
// fill up, in_stall rises once they are all full, and the pipeline holds its
// contents.
// ----------------------------------------------------------------------------
module null_aware_int64_aggregate_unit
  import nai64_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DATA_W-1:0]  in_value_0,
  input  logic [DATA_W-1:0]  in_value_1,
  input  logic [DATA_W-1:0]  in_value_2,
  input  logic [DATA_W-1:0]  in_value_3,
  input  logic [DATA_W-1:0]  in_value_4,
  input  logic [DATA_W-1:0]  in_value_5,
  input  logic [DATA_W-1:0]  in_value_6,
  input  logic [DATA_W-1:0]  in_value_7,
  input  logic [LANES_W-1:0] in_lanes_used,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COUNT_W-1:0] out_non_null_count,
  output logic [DATA_W-1:0]  out_total,
  output logic [DATA_W-1:0]  out_smallest,
  output logic [DATA_W-1:0]  out_largest
);

  logic [DATA_W-1:0] values [8];
  partial_t          lane_part [LANES];
  partial_t          root_part;
  pipe_ctl_t         in_ctl;
  pipe_ctl_t         root_ctl;
  logic              lane_en;
  logic              acc_ready;

  assign values[0] = in_value_0;
  assign values[1] = in_value_1;
  assign values[2] = in_value_2;
  assign values[3] = in_value_3;
  assign values[4] = in_value_4;
  assign values[5] = in_value_5;
  assign values[6] = in_value_6;
  assign values[7] = in_value_7;

  assign in_ctl   = '{valid: in_valid, last: in_last};
  assign in_stall = !lane_en;

  // One filter lane per element of the request.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    nai64_lane u_lane (
      .clk    (clk),
      .en     (lane_en),
      .active (in_lanes_used > LANES_W'(i)),
      .value  (values[i]),
      .part   (lane_part[i])
    );
  end

  // Merge the lanes of one request.
  nai64_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (in_ctl),
    .lane_part (lane_part),
    .lane_en   (lane_en),
    .acc_ready (acc_ready),
    .root_part (root_part),
    .root_ctl  (root_ctl)
  );

  // Fold into the column aggregates and hold the result.
  nai64_acc u_acc (
    .clk                (clk),
    .rst_n              (rst_n),
    .part               (root_part),
    .ctl                (root_ctl),
    .ready              (acc_ready),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_non_null_count (out_non_null_count),
    .out_total          (out_total),
    .out_smallest       (out_smallest),
    .out_largest        (out_largest)
  );

endmodule

FILE: hdl/nai64_lane.sv
// ----------------------------------------------------------------------------
// nai64_lane
// One input lane: drops nulls and unused lanes, registers a lane partial.
// ----------------------------------------------------------------------------
module nai64_lane
  import nai64_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic              active,
  input  logic [DATA_W-1:0] value,
  output partial_t          part
);

  partial_t part_r;
  partial_t part_nxt;

  // A real, non-null element counts once and seeds sum, minimum and maximum.
  always_comb begin
    if (active && (value != NULL_MARK)) begin
      part_nxt.cnt = CNT_W'(1);
      part_nxt.sum = value;
      part_nxt.lo  = value;
      part_nxt.hi  = value;
    end else begin
      part_nxt = EMPTY_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part_r <= part_nxt;
    end
  end

  assign part = part_r;

endmodule

FILE: hdl/nai64_merge.sv
// ----------------------------------------------------------------------------
// nai64_merge
// Registered pairwise tree that merges the lane partials of one request.
// ----------------------------------------------------------------------------
module nai64_merge
  import nai64_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pipe_ctl_t in_ctl,
  input  partial_t  lane_part [LANES],
  output logic      lane_en,
  input  logic      acc_ready,
  output partial_t  root_part,
  output pipe_ctl_t root_ctl
);

  // Stage 0 is the lane register; stages 1 to LEVELS are tree levels.
  pipe_ctl_t ctl_r [LEVELS+1];
  logic      ready [LEVELS+2];
  partial_t  tree  [NODES];

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    ready[LEVELS+1] = acc_ready;
    for (int k = LEVELS; k >= 0; k--) begin
      ready[k] = !ctl_r[k].valid || ready[k+1];
    end
  end

  assign lane_en = ready[0];

  // Request control moves along with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LEVELS; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      if (ready[0]) begin
        ctl_r[0] <= in_ctl;
      end
      for (int k = 1; k <= LEVELS; k++) begin
        if (ready[k]) begin
          ctl_r[k] <= ctl_r[k-1];
        end
      end
    end
  end

  // Leaves of the heap: lane partials, padded with empty ones.
  for (genvar i = 0; i < LANE_PAD; i++) begin : g_leaf
    if (i < LANES) begin : g_real
      assign tree[LANE_PAD-1+i] = lane_part[i];
    end else begin : g_pad
      assign tree[LANE_PAD-1+i] = EMPTY_PARTIAL;
    end
  end

  // Internal nodes, each a register loaded when its level advances.
  for (genvar k = 0; k < LANE_PAD - 1; k++) begin : g_node
    localparam int STG = node_stage(k);
    partial_t node_r;

    always_ff @(posedge clk) begin
      if (ready[STG]) begin
        node_r <= merge_pair(tree[2*k+1], tree[2*k+2]);
      end
    end

    assign tree[k] = node_r;
  end

  assign root_part = tree[0];
  assign root_ctl  = ctl_r[LEVELS];

endmodule

FILE: hdl/nai64_acc.sv
// ----------------------------------------------------------------------------
// nai64_acc
// Running aggregates of the column and the result register.
// ----------------------------------------------------------------------------
module nai64_acc
  import nai64_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  partial_t           part,
  input  pipe_ctl_t          ctl,
  output logic               ready,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [COUNT_W-1:0] out_non_null_count,
  output logic [DATA_W-1:0]  out_total,
  output logic [DATA_W-1:0]  out_smallest,
  output logic [DATA_W-1:0]  out_largest
);

  logic [COUNT_W-1:0] run_cnt_r;
  logic [DATA_W-1:0]  run_sum_r;
  logic [DATA_W-1:0]  run_lo_r;
  logic [DATA_W-1:0]  run_hi_r;

  logic               out_valid_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic [DATA_W-1:0]  out_sum_r;
  logic [DATA_W-1:0]  out_lo_r;
  logic [DATA_W-1:0]  out_hi_r;

  logic               out_free;
  logic               take;
  logic [COUNT_W:0]   cnt_sum;
  logic [COUNT_W-1:0] cnt_nxt;
  logic [DATA_W-1:0]  sum_nxt;
  logic [DATA_W-1:0]  lo_nxt;
  logic [DATA_W-1:0]  hi_nxt;

  // A last request needs room in the result register; others never wait.
  assign out_free = !out_valid_r || !out_stall;
  assign ready    = !ctl.valid || !ctl.last || out_free;
  assign take     = ctl.valid && (!ctl.last || out_free);

  // Fold the request partial into the running values; the count saturates.
  always_comb begin
    cnt_sum = {1'b0, run_cnt_r} + (COUNT_W+1)'(part.cnt);
    cnt_nxt = cnt_sum[COUNT_W] ? {COUNT_W{1'b1}} : cnt_sum[COUNT_W-1:0];
    sum_nxt = run_sum_r + part.sum;
    if (run_cnt_r == '0) begin
      lo_nxt = part.lo;
      hi_nxt = part.hi;
    end else if (part.cnt == '0) begin
      lo_nxt = run_lo_r;
      hi_nxt = run_hi_r;
    end else begin
      lo_nxt = ($signed(part.lo) < $signed(run_lo_r)) ? part.lo : run_lo_r;
      hi_nxt = ($signed(part.hi) > $signed(run_hi_r)) ? part.hi : run_hi_r;
    end
  end

  // Running state: updated per request, cleared after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
      run_sum_r <= '0;
      run_lo_r  <= NULL_MARK;
      run_hi_r  <= NULL_MARK;
    end else if (take) begin
      if (ctl.last) begin
        run_cnt_r <= '0;
        run_sum_r <= '0;
        run_lo_r  <= NULL_MARK;
        run_hi_r  <= NULL_MARK;
      end else begin
        run_cnt_r <= cnt_nxt;
        run_sum_r <= sum_nxt;
        run_lo_r  <= lo_nxt;
        run_hi_r  <= hi_nxt;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && ctl.last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; a column with no non-null value reports the null mark.
  always_ff @(posedge clk) begin
    if (take && ctl.last) begin
      out_cnt_r <= cnt_nxt;
      if (cnt_nxt == '0) begin
        out_sum_r <= NULL_MARK;
        out_lo_r  <= NULL_MARK;
        out_hi_r  <= NULL_MARK;
      end else begin
        out_sum_r <= sum_nxt;
        out_lo_r  <= lo_nxt;
        out_hi_r  <= hi_nxt;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_non_null_count = out_cnt_r;
  assign out_total          = out_sum_r;
  assign out_smallest       = out_lo_r;
  assign out_largest        = out_hi_r;

  // The running state is clear right after a column closes.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && ctl.last) |=> (run_cnt_r == '0 && run_sum_r == '0))
    else $error("running state not cleared after last request");

  // With nothing counted, minimum and maximum still hold the null mark.
  a_empty_running: assert property (@(posedge clk) disable iff (!rst_n)
    (run_cnt_r == '0) |-> (run_lo_r == NULL_MARK && run_hi_r == NULL_MARK))
    else $error("running min/max set while count is zero");

  // Minimum never exceeds maximum once something was counted.
  a_running_order: assert property (@(posedge clk) disable iff (!rst_n)
    (run_cnt_r != '0) |-> ($signed(run_lo_r) <= $signed(run_hi_r)))
    else $error("running minimum above running maximum");

  // An empty result reports the null mark in every value field.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cnt_r == '0) |->
      (out_sum_r == NULL_MARK && out_lo_r == NULL_MARK && out_hi_r == NULL_MARK))
    else $error("empty column result without null mark");

  // A waiting result is never overwritten by a new last request.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(take && ctl.last))
    else $error("pending result overwritten");

endmodule
